### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// Shared concurrent assertion macros for the sorted insertion store.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define SIS_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sorted insertion store assertion failed");
// antecedent implies consequent in the next cycle
`define SIS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sorted insertion store assertion failed");
`else
`define SIS_ASSERT_SAME(label, clk, rst, ante, cons)
`define SIS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### rtl/core/sis_pkg.sv
// ----------------------------------------------------------------------------
// sis_pkg
// Types and constants shared by the sorted insertion store modules.
// ----------------------------------------------------------------------------
package sis_pkg;

   // store geometry
   localparam int DEPTH   = 32;
   localparam int COUNT_W = $clog2(DEPTH + 1);
   localparam int VALUE_W = 32;
   localparam int FILL_W  = 6;

   // request action codes
   typedef enum logic [1:0] {
      ACT_INSERT = 2'd0,
      ACT_DUMP   = 2'd1,
      ACT_CLEAR  = 2'd2
   } action_type;

   // response status codes
   typedef enum logic [2:0] {
      ST_INSERTED = 3'd0,
      ST_FULL     = 3'd1,
      ST_ENTRY    = 3'd2,
      ST_EMPTY    = 3'd3,
      ST_CLEARED  = 3'd4
   } status_type;

   // datapath operation on the cell chain
   typedef enum logic [1:0] {
      OP_HOLD,
      OP_INSERT,
      OP_ROTATE,
      OP_CLEAR
   } op_type;

   // controller states
   typedef enum logic {
      S_IDLE,
      S_DUMP
   } state_type;

   // controller to datapath command
   typedef struct packed {
      op_type     op;
      logic       load_out;
      status_type status;
      logic       emit_entry;
      logic       last;
   } dp_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic [COUNT_W-1:0] count;
      logic               full;
      logic               empty;
   } dp_stat_type;

endpackage

### rtl/core/sis_datapath.sv
// ----------------------------------------------------------------------------
// sis_datapath
// Compare-and-shift cell chain, entry count and response payload register.
// ----------------------------------------------------------------------------
module sis_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  sis_pkg::dp_cmd_type                cmd,
   input  logic signed [sis_pkg::VALUE_W-1:0] item_value,
   output sis_pkg::dp_stat_type               stat,
   output sis_pkg::status_type                rsp_status,
   output logic signed [sis_pkg::VALUE_W-1:0] rsp_value,
   output logic                               rsp_last,
   output logic [sis_pkg::FILL_W-1:0]         rsp_fill
);
   import sis_pkg::*;

   logic signed [VALUE_W-1:0] cell_ff [DEPTH];
   logic signed [VALUE_W-1:0] cell_in [DEPTH];
   logic [DEPTH-1:0]          gt;
   logic [COUNT_W-1:0]        count_ff;
   logic [COUNT_W-1:0]        count_in;
   status_type                status_ff;
   logic signed [VALUE_W-1:0] value_ff;
   logic                      last_ff;
   logic [FILL_W-1:0]         fill_ff;

   // per-cell compare and next value
   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic signed [VALUE_W-1:0] prev_value;
      logic                      prev_gt;
      logic signed [VALUE_W-1:0] next_value;

      assign gt[g] = (COUNT_W'(g) < count_ff) && (cell_ff[g] > item_value);

      if (g > 0) begin : g_prev
         assign prev_value = cell_ff[g-1];
         assign prev_gt    = gt[g-1];
      end else begin : g_first
         assign prev_value = item_value;
         assign prev_gt    = 1'b0;
      end

      if (g < DEPTH - 1) begin : g_next
         assign next_value = cell_ff[g+1];
      end else begin : g_last
         assign next_value = cell_ff[g];
      end

      always_comb begin
         cell_in[g] = cell_ff[g];
         case (cmd.op)
            OP_INSERT: begin
               if (prev_gt) begin
                  cell_in[g] = prev_value;
               end else if (gt[g] || COUNT_W'(g) == count_ff) begin
                  cell_in[g] = item_value;
               end
            end
            OP_ROTATE: begin
               // head entry wraps to the end of the occupied run
               if (COUNT_W'(g + 1) == count_ff) begin
                  cell_in[g] = cell_ff[0];
               end else if (COUNT_W'(g) < count_ff) begin
                  cell_in[g] = next_value;
               end
            end
            default: cell_in[g] = cell_ff[g];
         endcase
      end
   end

   // entry count update
   always_comb begin
      case (cmd.op)
         OP_INSERT: count_in = count_ff + COUNT_W'(1);
         OP_CLEAR:  count_in = '0;
         default:   count_in = count_ff;
      endcase
   end

   // cell storage
   always_ff @(posedge clock) begin
      for (int i = 0; i < DEPTH; i++) begin
         cell_ff[i] <= cell_in[i];
      end
   end

   // entry count register
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // response payload register
   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         status_ff <= cmd.status;
         value_ff  <= cmd.emit_entry ? cell_ff[0] : '0;
         last_ff   <= cmd.last;
         fill_ff   <= FILL_W'(count_in);
      end
   end

   assign stat.count = count_ff;
   assign stat.full  = (count_ff == COUNT_W'(DEPTH));
   assign stat.empty = (count_ff == '0);
   assign rsp_status = status_ff;
   assign rsp_value  = value_ff;
   assign rsp_last   = last_ff;
   assign rsp_fill   = fill_ff;

endmodule

### rtl/core/sis_ctrl.sv
// ----------------------------------------------------------------------------
// sis_ctrl
// Request decode, dump sequencing and response valid control.
// ----------------------------------------------------------------------------
module sis_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [1:0]           action,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  sis_pkg::dp_stat_type stat,
   output sis_pkg::dp_cmd_type  cmd
);
   import sis_pkg::*;

   state_type          state_ff;
   state_type          state_in;
   logic [COUNT_W-1:0] rem_ff;
   logic [COUNT_W-1:0] rem_in;
   logic               out_valid_ff;
   logic               out_valid_in;
   logic               slot_free;

   // state and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rem_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rem_ff       <= rem_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // next state and commands
   always_comb begin
      slot_free      = !out_valid_ff || rsp_tready;
      state_in       = state_ff;
      rem_in         = rem_ff;
      out_valid_in   = out_valid_ff && !rsp_tready;
      req_tready     = 1'b0;
      cmd.op         = OP_HOLD;
      cmd.load_out   = 1'b0;
      cmd.status     = ST_INSERTED;
      cmd.emit_entry = 1'b0;
      cmd.last       = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = slot_free;
            if (req_tvalid && slot_free) begin
               case (action)
                  ACT_INSERT: begin
                     cmd.load_out = 1'b1;
                     if (stat.full) begin
                        cmd.status = ST_FULL;
                     end else begin
                        cmd.op     = OP_INSERT;
                        cmd.status = ST_INSERTED;
                     end
                  end
                  ACT_DUMP: begin
                     cmd.load_out = 1'b1;
                     if (stat.empty) begin
                        cmd.status = ST_EMPTY;
                     end else begin
                        cmd.op         = OP_ROTATE;
                        cmd.status     = ST_ENTRY;
                        cmd.emit_entry = 1'b1;
                        cmd.last       = (stat.count == COUNT_W'(1));
                        rem_in         = stat.count - COUNT_W'(1);
                        if (stat.count != COUNT_W'(1)) begin
                           state_in = S_DUMP;
                        end
                     end
                  end
                  ACT_CLEAR: begin
                     cmd.load_out = 1'b1;
                     cmd.op       = OP_CLEAR;
                     cmd.status   = ST_CLEARED;
                  end
                  default: cmd.load_out = 1'b0;
               endcase
               out_valid_in = out_valid_in || cmd.load_out;
            end
         end
         S_DUMP: begin
            // one entry per free output slot, head of chain then rotate
            if (slot_free) begin
               cmd.op         = OP_ROTATE;
               cmd.load_out   = 1'b1;
               cmd.status     = ST_ENTRY;
               cmd.emit_entry = 1'b1;
               cmd.last       = (rem_ff == COUNT_W'(1));
               rem_in         = rem_ff - COUNT_W'(1);
               out_valid_in   = 1'b1;
               if (rem_ff == COUNT_W'(1)) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_tvalid = out_valid_ff;

endmodule

### rtl/core/sorted_insertion_store.sv
// ----------------------------------------------------------------------------
// sorted_insertion_store
// Keeps up to 32 signed values in ascending order with stable ties.
// ----------------------------------------------------------------------------
// Insert, clear and a dump of an empty store each give one transfer; a new
// request is taken every cycle as long as the response side keeps up. Inserts
// go into a chain of compare-and-shift cells. A dump of n entries gives n
// transfers, one per cycle while the response side keeps up, read from the
// head of the chain while it rotates, and no request is taken until the last
// of them is loaded into the response register. An insert into a full store
// is dropped and reported.
`include "assert_macros.svh"

module sorted_insertion_store (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // [31:0] item_value
   input  logic [1:0]  req_tuser,  // [1:0] action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,  // [31:0] entry_value, [37:32] fill_count, zero pad
   output logic [2:0]  rsp_tuser,  // [2:0] status
   output logic        rsp_tlast
);
   import sis_pkg::*;

   dp_cmd_type                cmd;
   dp_stat_type               stat;
   status_type                rsp_status;
   logic signed [VALUE_W-1:0] rsp_value;
   logic [FILL_W-1:0]         rsp_fill;

   // control
   sis_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .action     (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // cell chain and response payload
   sis_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .item_value (signed'(req_tdata)),
      .stat       (stat),
      .rsp_status (rsp_status),
      .rsp_value  (rsp_value),
      .rsp_last   (rsp_tlast),
      .rsp_fill   (rsp_fill)
   );

   // response packing
   assign rsp_tdata = {2'b00, rsp_fill, rsp_value};
   assign rsp_tuser = rsp_status;

   // checks
   `SIS_ASSERT_SAME(a_full_flag, clock, reset, rsp_tvalid && rsp_tuser == ST_FULL, rsp_tdata[37:32] == FILL_W'(DEPTH))
   `SIS_ASSERT_SAME(a_empty_flag, clock, reset, rsp_tvalid && rsp_tuser == ST_EMPTY, rsp_tdata[37:32] == '0 && rsp_tlast)
   `SIS_ASSERT_NEXT(a_clear_count, clock, reset, req_tvalid && req_tready && req_tuser == ACT_CLEAR, stat.count == '0)
   `SIS_ASSERT_SAME(a_count_bound, clock, reset, 1'b1, stat.count <= COUNT_W'(DEPTH))

endmodule
